### rtl/mtkte_pkg.sv
// Shared types, codes and key tables for the multi-tap keypad text entry block.
package mtkte_pkg;

  // Input commands
  localparam logic [1:0] CMD_TOUCH = 2'd0;
  localparam logic [1:0] CMD_TICK  = 2'd1;
  localparam logic [1:0] CMD_CAPS  = 2'd2;

  // Result event kinds
  localparam logic [1:0] EV_NONE  = 2'd0;
  localparam logic [1:0] EV_BACK  = 2'd1;
  localparam logic [1:0] EV_OK    = 2'd2;
  localparam logic [1:0] EV_CHAR  = 2'd3;

  // Classified operations passed from front to back
  localparam logic [2:0] OP_NOP   = 3'd0;
  localparam logic [2:0] OP_TICK  = 3'd1;
  localparam logic [2:0] OP_CAPS  = 3'd2;
  localparam logic [2:0] OP_BACK  = 3'd3;
  localparam logic [2:0] OP_OK    = 3'd4;
  localparam logic [2:0] OP_DIGIT = 3'd5;

  // Configuration register indexes
  localparam logic CFG_MAX_LENGTH = 1'b0;
  localparam logic CFG_WAIT_TICKS = 1'b1;

  localparam logic [7:0]  DEFAULT_LIMIT      = 8'd64;
  localparam logic [7:0]  RESET_MAX_LENGTH   = 8'd0;
  localparam logic [15:0] RESET_WAIT_TICKS   = 16'd3000;

  // Keypad geometry
  localparam logic [8:0] GRID_LEFT   = 9'd4;
  localparam logic [8:0] GRID_TOP    = 9'd28;
  localparam logic [8:0] GRID_RIGHT  = 9'd198;  // left + 3 * pitch - gap
  localparam logic [8:0] GRID_BOTTOM = 9'd200;  // top + 4 * pitch - gap
  localparam logic [8:0] PITCH_X     = 9'd66;
  localparam logic [8:0] PITCH_Y     = 9'd44;
  localparam logic [8:0] KEY_WIDTH   = 9'd62;
  localparam logic [8:0] KEY_HEIGHT  = 9'd40;

  localparam logic [3:0] KEY_BACK = 4'd10;
  localparam logic [3:0] KEY_OK   = 4'd11;

  typedef struct packed {
    logic [1:0] command;
    logic [8:0] touch_x;
    logic [8:0] touch_y;
    logic [7:0] text_length;
  } item_t;

  typedef struct packed {
    logic [1:0] event_kind;
    logic [6:0] char_code;
    logic       remove_last;
    logic       append_char;
    logic       expired;
  } result_t;

  typedef struct packed {
    logic [2:0] op;
    logic [3:0] key;
    logic [7:0] text_length;
  } op_t;

  // Key at grid slot row * 3 + col
  function automatic logic [3:0] grid_key(input logic [3:0] slot);
    logic [3:0] k;
    case (slot)
      4'd0:    k = 4'd1;
      4'd1:    k = 4'd2;
      4'd2:    k = 4'd3;
      4'd3:    k = 4'd4;
      4'd4:    k = 4'd5;
      4'd5:    k = 4'd6;
      4'd6:    k = 4'd7;
      4'd7:    k = 4'd8;
      4'd8:    k = 4'd9;
      4'd9:    k = KEY_BACK;
      4'd10:   k = 4'd0;
      default: k = KEY_OK;
    endcase
    return k;
  endfunction

  // Number of characters on a digit key, its own digit included
  function automatic logic [3:0] key_len(input logic [3:0] key);
    logic [3:0] n;
    case (key) inside
      4'd1:         n = 4'd8;
      4'd7, 4'd9:   n = 4'd5;
      default:      n = 4'd4;
    endcase
    return n;
  endfunction

  // Character at a position of a digit key (letters in lower case)
  function automatic logic [7:0] key_letter(input logic [3:0] key, input logic [2:0] pos);
    logic [7:0] c;
    c = "0";
    case (key)
      4'd0: case (pos)
        3'd0: c = " "; 3'd1: c = "_"; 3'd2: c = "+"; default: c = "0";
      endcase
      4'd1: case (pos)
        3'd0: c = "."; 3'd1: c = ","; 3'd2: c = "?"; 3'd3: c = "!";
        3'd4: c = "/"; 3'd5: c = "-"; 3'd6: c = "_"; default: c = "1";
      endcase
      4'd2: case (pos)
        3'd0: c = "a"; 3'd1: c = "b"; 3'd2: c = "c"; default: c = "2";
      endcase
      4'd3: case (pos)
        3'd0: c = "d"; 3'd1: c = "e"; 3'd2: c = "f"; default: c = "3";
      endcase
      4'd4: case (pos)
        3'd0: c = "g"; 3'd1: c = "h"; 3'd2: c = "i"; default: c = "4";
      endcase
      4'd5: case (pos)
        3'd0: c = "j"; 3'd1: c = "k"; 3'd2: c = "l"; default: c = "5";
      endcase
      4'd6: case (pos)
        3'd0: c = "m"; 3'd1: c = "n"; 3'd2: c = "o"; default: c = "6";
      endcase
      4'd7: case (pos)
        3'd0: c = "p"; 3'd1: c = "q"; 3'd2: c = "r"; 3'd3: c = "s"; default: c = "7";
      endcase
      4'd8: case (pos)
        3'd0: c = "t"; 3'd1: c = "u"; 3'd2: c = "v"; default: c = "8";
      endcase
      default: case (pos)
        3'd0: c = "w"; 3'd1: c = "x"; 3'd2: c = "y"; 3'd3: c = "z"; default: c = "9";
      endcase
    endcase
    return c;
  endfunction

endpackage

### rtl/mtkte_front.sv
// Front end: maps an input item to a classified operation and a key.
module mtkte_front (
  input  mtkte_pkg::item_t item,
  output mtkte_pkg::op_t   op
);
  import mtkte_pkg::*;

  logic       in_grid;
  logic [8:0] xr;
  logic [8:0] yr;
  logic [1:0] col;
  logic [1:0] row;
  logic [8:0] off_x;
  logic [8:0] off_y;
  logic       in_key;
  logic [3:0] slot;
  logic [3:0] key;

  always_comb begin
    in_grid = (item.touch_x >= GRID_LEFT) && (item.touch_x < GRID_RIGHT) &&
              (item.touch_y >= GRID_TOP) && (item.touch_y < GRID_BOTTOM);
    xr = item.touch_x - GRID_LEFT;
    yr = item.touch_y - GRID_TOP;

    if (xr >= 9'(2 * PITCH_X)) begin
      col   = 2'd2;
      off_x = xr - 9'(2 * PITCH_X);
    end else if (xr >= PITCH_X) begin
      col   = 2'd1;
      off_x = xr - PITCH_X;
    end else begin
      col   = 2'd0;
      off_x = xr;
    end

    if (yr >= 9'(3 * PITCH_Y)) begin
      row   = 2'd3;
      off_y = yr - 9'(3 * PITCH_Y);
    end else if (yr >= 9'(2 * PITCH_Y)) begin
      row   = 2'd2;
      off_y = yr - 9'(2 * PITCH_Y);
    end else if (yr >= PITCH_Y) begin
      row   = 2'd1;
      off_y = yr - PITCH_Y;
    end else begin
      row   = 2'd0;
      off_y = yr;
    end

    // drop touches that land in a gap between keys
    in_key = in_grid && (off_x < KEY_WIDTH) && (off_y < KEY_HEIGHT);
    slot   = 4'({2'b00, row} * 4'd3) + {2'b00, col};
    key    = grid_key(slot);

    op.key         = key;
    op.text_length = item.text_length;
    unique case (item.command)
      CMD_TICK:  op.op = OP_TICK;
      CMD_CAPS:  op.op = OP_CAPS;
      CMD_TOUCH: begin
        if (!in_key)
          op.op = OP_NOP;
        else if (key == KEY_BACK)
          op.op = OP_BACK;
        else if (key == KEY_OK)
          op.op = OP_OK;
        else
          op.op = OP_DIGIT;
      end
      default:   op.op = OP_NOP;
    endcase
  end

endmodule

### rtl/mtkte_queue.sv
// Short FIFO of classified operations between front and back.
module mtkte_queue #(
  parameter int DEPTH = 2
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  input  mtkte_pkg::op_t push_data,
  output logic           full,
  input  logic           pop,
  output logic           not_empty,
  output mtkte_pkg::op_t pop_data
);
  import mtkte_pkg::*;

  localparam int              PtrW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int              CntW    = $clog2(DEPTH + 1);
  localparam logic [PtrW-1:0] LastIdx = PtrW'(DEPTH - 1);

  op_t             mem [DEPTH];
  logic [PtrW-1:0] wr_ptr;
  logic [PtrW-1:0] rd_ptr;
  logic [CntW-1:0] count;

  assign full      = (count == CntW'(DEPTH));
  assign not_empty = (count != '0);
  assign pop_data  = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_data;
    end
  end

  // wrap the pointers at the last entry
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= (wr_ptr == LastIdx) ? '0 : wr_ptr + 1'b1;
      if (pop)  rd_ptr <= (rd_ptr == LastIdx) ? '0 : rd_ptr + 1'b1;
      if (push && !pop)
        count <= count + 1'b1;
      else if (pop && !push)
        count <= count - 1'b1;
    end
  end

endmodule

### rtl/mtkte_back.sv
// Back end: pending key state, caps mode, configuration and result register.
module mtkte_back (
  input  logic               clk,
  input  logic               rst,
  input  logic               op_valid,
  input  mtkte_pkg::op_t     op,
  output logic               op_take,
  input  logic               cfg_write,
  input  logic               cfg_index,
  input  logic [15:0]        cfg_data,
  output logic               result_valid,
  input  logic               result_ready,
  output mtkte_pkg::result_t result
);
  import mtkte_pkg::*;

  logic [7:0]  max_length;
  logic [15:0] wait_ticks;

  logic        pending_valid;
  logic [3:0]  pending_key_code;
  logic [2:0]  pending_position;
  logic [15:0] pending_age;
  logic        caps_mode;

  logic        pending_valid_next;
  logic [3:0]  pending_key_code_next;
  logic [2:0]  pending_position_next;
  logic [15:0] pending_age_next;
  logic        caps_mode_next;
  result_t     result_next;

  logic        active;
  logic        same;
  logic [7:0]  limit;
  logic [15:0] age_inc;
  logic [3:0]  pos_inc;
  logic [7:0]  after;
  logic [7:0]  ch;

  assign op_take = op_valid && (!result_valid || result_ready);

  always_comb begin
    pending_valid_next    = pending_valid;
    pending_key_code_next = pending_key_code;
    pending_position_next = pending_position;
    pending_age_next      = pending_age;
    caps_mode_next        = caps_mode;
    result_next           = '0;

    active  = pending_valid && (pending_age < wait_ticks);
    same    = active && (pending_key_code == op.key);
    limit   = (max_length != 8'd0) ? max_length : DEFAULT_LIMIT;
    age_inc = (pending_age == 16'hFFFF) ? pending_age : pending_age + 16'd1;
    pos_inc = {1'b0, pending_position} + 4'd1;
    after   = op.text_length;
    ch      = 8'd0;

    unique case (op.op) inside
      OP_TICK: begin
        pending_age_next = age_inc;
        if (pending_valid && !(age_inc < wait_ticks)) begin
          pending_valid_next    = 1'b0;
          pending_key_code_next = 4'd0;
          pending_position_next = 3'd0;
          pending_age_next      = 16'd0;
          result_next.expired   = 1'b1;
        end
      end
      OP_CAPS: caps_mode_next = !caps_mode;
      OP_BACK, OP_OK: begin
        pending_valid_next    = 1'b0;
        pending_key_code_next = 4'd0;
        pending_position_next = 3'd0;
        pending_age_next      = 16'd0;
        if (op.op == OP_BACK) begin
          result_next.event_kind  = EV_BACK;
          result_next.remove_last = (op.text_length != 8'd0);
        end else begin
          result_next.event_kind = EV_OK;
        end
      end
      OP_DIGIT: begin
        if (same || (op.text_length < limit)) begin
          if (same) begin
            pending_position_next = (pos_inc == key_len(op.key)) ? 3'd0 : pos_inc[2:0];
            if (op.text_length != 8'd0) begin
              result_next.remove_last = 1'b1;
              after = op.text_length - 8'd1;
            end
          end else begin
            pending_valid_next    = 1'b1;
            pending_key_code_next = op.key;
            pending_position_next = 3'd0;
          end
          pending_age_next = 16'd0;
          ch = key_letter(op.key, pending_position_next);
          if (caps_mode && (ch >= "a") && (ch <= "z"))
            ch = ch - 8'd32;
          result_next.event_kind  = EV_CHAR;
          result_next.char_code   = ch[6:0];
          result_next.append_char = (after < limit);
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      max_length <= RESET_MAX_LENGTH;
      wait_ticks <= RESET_WAIT_TICKS;
    end else if (cfg_write) begin
      case (cfg_index)
        CFG_MAX_LENGTH: max_length <= cfg_data[7:0];
        default:        wait_ticks <= cfg_data;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pending_valid    <= 1'b0;
      pending_key_code <= 4'd0;
      pending_position <= 3'd0;
      pending_age      <= 16'd0;
      caps_mode        <= 1'b0;
      result_valid     <= 1'b0;
    end else begin
      if (op_take) begin
        pending_valid    <= pending_valid_next;
        pending_key_code <= pending_key_code_next;
        pending_position <= pending_position_next;
        pending_age      <= pending_age_next;
        caps_mode        <= caps_mode_next;
        result_valid     <= 1'b1;
      end else if (result_ready) begin
        result_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (op_take) begin
      result <= result_next;
    end
  end

endmodule

### rtl/multitap_keypad_text_entry.sv
// Top level of the multi-tap keypad text entry block.
//
//   channel  | handshake                  | payload
//   ---------+----------------------------+----------------------------
//   item     | item_valid / item_ready    | item   (item_t)
//   result   | result_valid / result_ready| result (result_t)
//   cfg      | cfg_valid / cfg_ready      | cfg_index, cfg_data
//
// One item per clock is sustained while result_ready stays high; each item
// passes through the queue and then the result register before its result shows.
// The queue of QUEUE_DEPTH entries lets the front keep taking transfers while
// the result register stalls; item_ready drops only when the queue is full.
// Reset (rst, synchronous) empties the queue, clears the pending key and caps
// mode, and loads the register defaults. cfg_ready is always high.
module multitap_keypad_text_entry #(
  parameter int QUEUE_DEPTH = 2
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               item_valid,
  output logic               item_ready,
  input  mtkte_pkg::item_t   item,
  output logic               result_valid,
  input  logic               result_ready,
  output mtkte_pkg::result_t result,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic               cfg_index,
  input  logic [15:0]        cfg_data
);
  import mtkte_pkg::*;

  op_t  front_op;
  op_t  queue_op;
  logic queue_full;
  logic queue_not_empty;
  logic op_take;

  assign item_ready = !queue_full;
  assign cfg_ready  = 1'b1;

  mtkte_front u_front (
    .item (item),
    .op   (front_op)
  );

  mtkte_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (item_valid && item_ready),
    .push_data (front_op),
    .full      (queue_full),
    .pop       (op_take),
    .not_empty (queue_not_empty),
    .pop_data  (queue_op)
  );

  mtkte_back u_back (
    .clk          (clk),
    .rst          (rst),
    .op_valid     (queue_not_empty),
    .op           (queue_op),
    .op_take      (op_take),
    .cfg_write    (cfg_valid && cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result       (result)
  );

endmodule
